// ===== src/bole_pkg.sv =====
// Package with types, codes and sizes shared by the ordered list engine.
`timescale 1ns / 1ps
package bole_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 16;
  // Width of the internal entry count, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Command codes.
  localparam logic [1:0] OP_INS_FRONT = 2'd0;
  localparam logic [1:0] OP_INS_BACK  = 2'd1;
  localparam logic [1:0] OP_SEARCH    = 2'd2;
  localparam logic [1:0] OP_REMOVE    = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // One command transaction.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] position;
    logic [4:0] entry_count;
  } rsp_t;

  // Per-cycle shift control broadcast to every cell.
  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic remove;
  } cell_ctl_t;

endpackage

// ===== src/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: a row of compare-and-shift cells.
//
//  Channel | Signals                      | Payload
//  --------+------------------------------+------------------------------------
//  command | cmd_valid, cmd_ready, cmd    | op, value
//  result  | rsp_valid, rsp_ready, rsp    | status, found, position, entry_count
//
// All cells compare and shift together for every command, and the result is
// registered, so one transaction per cycle is sustained while the result side
// drains. The first-match flag ripples combinationally through the cell row.
// Reset clears every occupancy flag and the count; entry payloads are not reset.
// A stalled result holds; a new command is taken only when the result register
// is empty or being drained in the same cycle.
`timescale 1ns / 1ps
module bounded_ordered_list_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bole_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bole_pkg::rsp_t rsp
);
  import bole_pkg::*;

  logic signed [31:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY-1:0] cell_first;
  logic [CNT_W-1:0]    held_count;
  logic [CNT_W-1:0]    held_count_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic                any_hit;
  logic                is_insert;
  logic [3:0]          match_pos;
  cell_ctl_t           ctl;
  rsp_t                rsp_next;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign full      = cell_valid[CAPACITY-1];
  assign empty     = !cell_valid[0];
  assign any_hit   = cell_hit[CAPACITY-1];
  assign is_insert = (cmd.op == OP_INS_FRONT) || (cmd.op == OP_INS_BACK);

  // Shift control, applied only for a transaction that changes the list.
  always_comb begin
    ctl.ins_front = accept && (cmd.op == OP_INS_FRONT) && !full;
    ctl.ins_back  = accept && (cmd.op == OP_INS_BACK) && !full;
    ctl.remove    = accept && (cmd.op == OP_REMOVE) && any_hit;
  end

  // Row of cells; cell 0 is the front of the list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lv;
    logic               lval;
    logic signed [31:0] rv;
    logic               rval;
    logic               hin;

    if (i == 0) begin : g_front
      assign lv   = cmd.value;
      assign lval = 1'b1;
      assign hin  = 1'b0;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lval = cell_valid[i-1];
      assign hin  = cell_hit[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign rv   = cmd.value;
      assign rval = 1'b0;
    end else begin : g_inner
      assign rv   = cell_value[i+1];
      assign rval = cell_valid[i+1];
    end

    bole_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key         (cmd.value),
      .left_value  (lv),
      .left_valid  (lval),
      .right_value (rv),
      .right_valid (rval),
      .hit_in      (hin),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .hit_out     (cell_hit[i]),
      .first       (cell_first[i])
    );
  end

  // Encode the one-hot first-match vector into an index.
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_first[i]) begin
        match_pos = match_pos | 4'(i);
      end
    end
  end

  // Status, result fields and the next count.
  always_comb begin
    held_count_next      = held_count;
    rsp_next.status      = ST_OK;
    rsp_next.found       = 1'b0;
    rsp_next.position    = '0;
    if (is_insert) begin
      if (full) begin
        rsp_next.status = ST_FULL;
      end else begin
        held_count_next = held_count + CNT_W'(1);
      end
    end else if (empty) begin
      rsp_next.status = ST_EMPTY;
    end else if (!any_hit) begin
      rsp_next.status = ST_NOT_FOUND;
    end else begin
      rsp_next.found    = 1'b1;
      rsp_next.position = match_pos;
      if (cmd.op == OP_REMOVE) begin
        held_count_next = held_count - CNT_W'(1);
      end
    end
    rsp_next.entry_count = 5'(32'(held_count_next));
  end

  // Entry count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/bole_cell.sv =====
// One list cell: holds an entry, compares it with the key and shifts with its neighbors.
`timescale 1ns / 1ps
module bole_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  bole_pkg::cell_ctl_t     ctl,
  input  logic signed [31:0]      key,
  input  logic signed [31:0]      left_value,
  input  logic                    left_valid,
  input  logic signed [31:0]      right_value,
  input  logic                    right_valid,
  input  logic                    hit_in,
  output logic signed [31:0]      value,
  output logic                    valid,
  output logic                    hit_out,
  output logic                    first
);
  import bole_pkg::*;

  logic match;

  // Match detection; the hit flag ripples toward the back of the list.
  assign match   = valid && (value == key);
  assign first   = match && !hit_in;
  assign hit_out = hit_in || match;

  // Entry payload: shift right on front insert, fill the boundary on back
  // insert, and close the gap from the right at and after the removed entry.
  always_ff @(posedge clk) begin
    priority if (ctl.ins_front) begin
      value <= left_value;
    end else if (ctl.ins_back && left_valid && !valid) begin
      value <= key;
    end else if (ctl.remove && hit_out) begin
      value <= right_value;
    end else begin
      value <= value;
    end
  end

  // Occupancy flag, moved along with the entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      priority if (ctl.ins_front) begin
        valid <= left_valid;
      end else if (ctl.ins_back && left_valid && !valid) begin
        valid <= 1'b1;
      end else if (ctl.remove && hit_out) begin
        valid <= right_valid;
      end else begin
        valid <= valid;
      end
    end
  end

endmodule

// ===== test/bole_list_checker.sv =====
// Checker for the ordered list engine: predicts each command's result and compares.
`timescale 1ns / 1ps
module bole_list_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_ready,
  input  bole_pkg::cmd_t cmd,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  bole_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending_count
);
  import bole_pkg::*;

  // Shadow copy of the list contents, front at index 0.
  logic signed [31:0] shadow_entries [CAPACITY];
  int                 shadow_count;

  // Results predicted for accepted commands, oldest first.
  rsp_t pending_results [$];
  int   mismatch_total;

  initial begin
    fail_count     = 0;
    pending_count  = 0;
    mismatch_total = 0;
    shadow_count   = 0;
  end

  // Applies one command to the shadow list and returns the result it should produce.
  function automatic rsp_t apply_list_command(cmd_t c);
    rsp_t r;
    int   hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    if (c.op == OP_INS_FRONT || c.op == OP_INS_BACK) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (c.op == OP_INS_FRONT) begin
        for (int i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[0] = c.value;
        shadow_count++;
      end else begin
        shadow_entries[shadow_count] = c.value;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // Only the first match counts.
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_entries[i] == c.value) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found    = 1'b1;
          r.position = hit[3:0];
          // Removal closes the gap toward the front.
          if (c.op == OP_REMOVE) begin
            for (int i = hit; i < shadow_count - 1; i++) begin
              shadow_entries[i] = shadow_entries[i+1];
            end
            shadow_count--;
          end
        end
      end
    end
    r.entry_count = shadow_count[4:0];
    return r;
  endfunction

  // Results are checked before new commands are queued, since a result can never
  // belong to a command accepted at the same edge.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      shadow_count = 0;
      pending_results.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("%0t: unexpected result transaction status=%0d found=%0d pos=%0d count=%0d",
                     $realtime, rsp.status, rsp.found, rsp.position, rsp.entry_count);
          end
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status || rsp.found !== want.found ||
              rsp.position !== want.position || rsp.entry_count !== want.entry_count) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: result mismatch: expected status=%0d found=%0d pos=%0d count=%0d",
                       $realtime, want.status, want.found, want.position, want.entry_count);
              $display("%0t:                  actual   status=%0d found=%0d pos=%0d count=%0d",
                       $realtime, rsp.status, rsp.found, rsp.position, rsp.entry_count);
            end
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        pending_results.push_back(apply_list_command(cmd));
      end
    end
    fail_count    <= mismatch_total;
    pending_count <= pending_results.size();
  end

endmodule

// ===== test/tb_bounded_ordered_list_engine.sv =====
// Testbench top for the ordered list engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module tb_bounded_ordered_list_engine;
  import bole_pkg::*;

  localparam int RANDOM_ITEMS  = 1550;
  localparam int SEGMENT_LEN   = 50;
  localparam int SEGMENTS      = RANDOM_ITEMS / SEGMENT_LEN;
  localparam int CALM_SEGMENTS = 3;
  localparam int POOL_SIZE     = 12;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   fail_count;
  int   pending_count;

  // Idle controls: idle_on is shared by both sides, gap_pct and stall_pct are per side.
  logic idle_on    = 1'b0;
  int   gap_pct    = 0;
  int   stall_pct  = 0;
  int   stall_left = 0;

  // Small pool of values so that searches and removals often hit.
  logic signed [31:0] value_pool [POOL_SIZE];

  always #6 clk = ~clk;

  bounded_ordered_list_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  bole_list_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Result side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(99, 0) < stall_pct) begin
      rsp_ready  <= 1'b0;
      stall_left <= $urandom_range(19, 1) - 1;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Presents one command and holds it until the engine takes it.
  task automatic send_command(input logic [1:0] op, input logic signed [31:0] value);
    cmd_t c;
    c.op    = op;
    c.value = value;
    if (idle_on && $urandom_range(99, 0) < gap_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // Stops sending until every predicted result has been received.
  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Fills the pool with a mix of extremes, small values and full-width random values.
  task automatic refill_pool();
    foreach (value_pool[i]) begin
      case ($urandom_range(5, 0))
        0:       value_pool[i] = 32'sh7FFF_FFFF;
        1:       value_pool[i] = 32'sh8000_0000;
        2:       value_pool[i] = $signed($urandom_range(4, 0)) - 2;
        default: value_pool[i] = $urandom();
      endcase
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99, 0) < 85) return value_pool[$urandom_range(POOL_SIZE - 1, 0)];
    return $urandom();
  endfunction

  // Biases the operation mix so the list regularly reaches both full and empty.
  function automatic logic [1:0] pick_op(op_mix_t mix);
    int r;
    r = $urandom_range(99, 0);
    case (mix)
      MIX_FILL: begin
        if (r < 38) return OP_INS_FRONT;
        if (r < 75) return OP_INS_BACK;
        if (r < 88) return OP_SEARCH;
        return OP_REMOVE;
      end
      MIX_DRAIN: begin
        if (r < 12) return OP_INS_FRONT;
        if (r < 25) return OP_INS_BACK;
        if (r < 40) return OP_SEARCH;
        return OP_REMOVE;
      end
      default: begin
        if (r < 25) return OP_INS_FRONT;
        if (r < 50) return OP_INS_BACK;
        if (r < 75) return OP_SEARCH;
        return OP_REMOVE;
      end
    endcase
  endfunction

  // Main stimulus.
  initial begin
    op_mix_t mix;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty list: search and removal both report empty.
    send_command(OP_SEARCH, 32'sd5);
    send_command(OP_REMOVE, 32'sd5);
    // Extremes at both ends, with a duplicate of minus one.
    send_command(OP_INS_FRONT, 32'sh7FFF_FFFF);
    send_command(OP_INS_BACK, 32'sh8000_0000);
    send_command(OP_INS_FRONT, -32'sd1);
    send_command(OP_INS_BACK, 32'sd0);
    send_command(OP_INS_BACK, -32'sd1);
    // Search hits the first duplicate, then a middle entry; a missing value is not found.
    send_command(OP_SEARCH, -32'sd1);
    send_command(OP_SEARCH, 32'sd0);
    send_command(OP_SEARCH, 32'sd12345);
    send_command(OP_REMOVE, 32'sd12345);
    // Remove the front entry, then the remaining duplicate at the back.
    send_command(OP_REMOVE, -32'sd1);
    send_command(OP_REMOVE, -32'sd1);
    // Fill to capacity, then try inserting at both ends.
    for (int i = 0; i < 13; i++) send_command(OP_INS_BACK, 32'sd100 + i);
    send_command(OP_INS_FRONT, 32'sd1);
    send_command(OP_INS_BACK, 32'sd2);
    // Last position, then removal from the back and a search near the front.
    send_command(OP_SEARCH, 32'sd112);
    send_command(OP_REMOVE, 32'sd112);
    send_command(OP_SEARCH, 32'sh8000_0000);
    wait_for_results();

    // Random segments, each with its own value pool, operation mix and idle settings.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      refill_pool();
      mix = op_mix_t'($urandom_range(2, 0));
      idle_on   <= (seg < SEGMENTS - CALM_SEGMENTS) && ($urandom_range(3, 0) != 0);
      gap_pct   <= $urandom_range(40, 5);
      stall_pct <= $urandom_range(40, 5);
      for (int k = 0; k < SEGMENT_LEN; k++) send_command(pick_op(mix), pick_value());
      if (seg % 5 == 4) wait_for_results();
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/bole_pkg.sv
src/bole_cell.sv
src/bounded_ordered_list_engine.sv
test/bole_list_checker.sv
test/tb_bounded_ordered_list_engine.sv
